@@ rtl/arithmetic_expression_lexer_defines.svh @@
// Assertion macros shared by the arithmetic expression lexer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ARITHMETIC_EXPRESSION_LEXER_DEFINES_SVH
`define ARITHMETIC_EXPRESSION_LEXER_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define AEL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ael assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define AEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ael assertion failed");
`else
`define AEL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AEL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ael_pkg.sv @@
// Package for the arithmetic expression lexer: constants, codes, beat types
// and the character classifier. No dependencies.
`timescale 1ns / 1ps

package ael_pkg;

    // Widths fixed by the result fields
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 4;
    localparam int TEXT_W          = 64;
    localparam int STATUS_W        = 3;
    localparam int MAX_TOKEN_CHARS = 8;
    // Byte index inside the token text (text holds up to eight characters)
    localparam int IDX_W           = 3;
    localparam logic [LEN_W-1:0] MAX_LEN_COUNT = LEN_W'(MAX_TOKEN_CHARS);

    // Character queue between classifier and scanner; depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;
    localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL_COUNT = QUEUE_CNT_W'(QUEUE_DEPTH);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    typedef enum logic [3:0] {
        CC_SPACE,
        CC_END,
        CC_DIGIT,
        CC_LETTER,
        CC_OPEN,
        CC_CLOSE,
        CC_SEMI,
        CC_OP_CHECKED,  // + - /
        CC_OP_STAR,
        CC_OTHER
    } t_char_class;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_OPER
    } t_scan_mode;

    typedef enum logic [1:0] {
        TT_DELIM,
        TT_OPER,
        TT_NUMBER,
        TT_IDENT
    } t_token_type;

    typedef enum logic {
        RK_TOKEN,
        RK_STATUS
    } t_result_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_SUFFIX,
        ST_DOUBLED_OP,
        ST_EMPTY_PAREN,
        ST_UNKNOWN_CHAR,
        ST_TOO_LONG
    } t_status_code;

    // One queued input beat: the character and its class
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        t_char_class       cls;
    } t_entry;

    // One output beat
    typedef struct packed {
        t_result_kind      kind;
        t_token_type       ttype;
        logic [LEN_W-1:0]  len;
        logic [TEXT_W-1:0] text;
        t_status_code      status;
        logic              last;
    } t_result;

    function automatic t_char_class classify(input logic [CHAR_W-1:0] c);
        t_char_class cls;
        if (c == CH_SPACE)                                   cls = CC_SPACE;
        else if (c == CH_HASH)                               cls = CC_END;
        else if (c >= CH_0 && c <= CH_9)                     cls = CC_DIGIT;
        else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ))
                                                             cls = CC_LETTER;
        else if (c == CH_LPAR)                               cls = CC_OPEN;
        else if (c == CH_RPAR)                               cls = CC_CLOSE;
        else if (c == CH_SEMI)                               cls = CC_SEMI;
        else if (c == CH_PLUS || c == CH_MINUS || c == CH_SLASH)
                                                             cls = CC_OP_CHECKED;
        else if (c == CH_STAR)                               cls = CC_OP_STAR;
        else                                                 cls = CC_OTHER;
        return cls;
    endfunction

    function automatic t_result mk_status(input t_status_code code);
        t_result r;
        r.kind   = RK_STATUS;
        r.ttype  = TT_DELIM;
        r.len    = '0;
        r.text   = '0;
        r.status = code;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_word(input t_token_type tt,
                                        input logic [LEN_W-1:0] len,
                                        input logic [TEXT_W-1:0] text);
        t_result r;
        r.kind   = RK_TOKEN;
        r.ttype  = tt;
        r.len    = len;
        r.text   = text;
        r.status = ST_OK;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_oper(input logic [CHAR_W-1:0] ch,
                                        input t_char_class cls);
        t_result r;
        r.kind   = RK_TOKEN;
        r.ttype  = (cls == CC_OPEN || cls == CC_CLOSE || cls == CC_SEMI) ? TT_DELIM : TT_OPER;
        r.len    = LEN_W'(1);
        r.text   = TEXT_W'(ch);
        r.status = ST_OK;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/ael_front.sv @@
// Front end of the lexer: accepts input beats and classifies each character.
// Depends on ael_pkg; feeds ael_queue.
`timescale 1ns / 1ps

module ael_front (
    input  logic                       i_in_valid,
    input  logic [ael_pkg::CHAR_W-1:0] i_in_char,
    output logic                       o_in_stall,
    input  logic                       i_queue_full,
    output logic                       o_push,
    output ael_pkg::t_entry            o_entry
);

    // Hold off the sender only when the queue has no free slot
    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Classify on the way in so the scanner sees a ready-made class code
    always_comb begin
        o_entry.ch  = i_in_char;
        o_entry.cls = ael_pkg::classify(i_in_char);
    end

endmodule

@@ rtl/ael_queue.sv @@
// Small FIFO of classified characters between front end and scanner.
// Depends on ael_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "arithmetic_expression_lexer_defines.svh"

module ael_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ael_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ael_pkg::t_entry o_data
);

    ael_pkg::t_entry                   r_mem [ael_pkg::QUEUE_DEPTH];
    logic [ael_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [ael_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [ael_pkg::QUEUE_CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == ael_pkg::QUEUE_FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `AEL_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full)
    `AEL_ASSERT_SAME(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, o_valid)
    `AEL_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= ael_pkg::QUEUE_FULL_COUNT)

endmodule

@@ rtl/ael_back.sv @@
// Back end of the lexer: scanner state machine, token buffer and output stage.
// Depends on ael_pkg and the assertion macro header; reads from ael_queue.
`timescale 1ns / 1ps
`include "arithmetic_expression_lexer_defines.svh"

module ael_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  ael_pkg::t_entry i_q_data,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ael_pkg::t_result o_result
);

    // Scanner state
    ael_pkg::t_scan_mode               r_mode, n_mode;
    logic [ael_pkg::LEN_W-1:0]         r_count, n_count;
    logic [ael_pkg::TEXT_W-1:0]        r_text, n_text;
    logic [ael_pkg::CHAR_W-1:0]        r_pend_ch, n_pend_ch;
    ael_pkg::t_char_class              r_pend_cls, n_pend_cls;

    // Output register and second-result holding slot
    ael_pkg::t_result                  r_out, n_out;
    logic                              r_out_valid, n_out_valid;
    ael_pkg::t_result                  r_second, n_second;
    logic                              r_second_valid, n_second_valid;

    // Idle-path handling of the current character
    logic                              idle_has;
    ael_pkg::t_result                  idle_res;
    ael_pkg::t_scan_mode               idle_mode;
    logic [ael_pkg::LEN_W-1:0]         idle_count;
    logic [ael_pkg::TEXT_W-1:0]        idle_text;
    logic [ael_pkg::CHAR_W-1:0]        idle_pch;
    ael_pkg::t_char_class              idle_pcls;

    // Results of the current character
    ael_pkg::t_result                  res_a, res_b;
    logic [1:0]                        res_n;
    ael_pkg::t_result                  word_res;
    logic                              word_cont;
    logic                              op_checked;
    logic                              out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = out_free && !r_second_valid && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // What idle does with a character
    always_comb begin
        idle_has   = 1'b0;
        idle_res   = ael_pkg::mk_status(ael_pkg::ST_OK);
        idle_mode  = ael_pkg::MODE_IDLE;
        idle_count = '0;
        idle_text  = r_text;
        idle_pch   = '0;
        idle_pcls  = ael_pkg::CC_SPACE;
        case (i_q_data.cls)
            ael_pkg::CC_SPACE: begin
                idle_has = 1'b0;
            end
            ael_pkg::CC_END: begin
                idle_has = 1'b1;
            end
            ael_pkg::CC_DIGIT, ael_pkg::CC_LETTER: begin
                idle_mode  = (i_q_data.cls == ael_pkg::CC_LETTER) ?
                             ael_pkg::MODE_IDENT : ael_pkg::MODE_NUMBER;
                idle_text  = ael_pkg::TEXT_W'(i_q_data.ch);
                idle_count = ael_pkg::LEN_W'(1);
            end
            ael_pkg::CC_OPEN, ael_pkg::CC_CLOSE, ael_pkg::CC_SEMI,
            ael_pkg::CC_OP_CHECKED, ael_pkg::CC_OP_STAR: begin
                idle_mode = ael_pkg::MODE_OPER;
                idle_pch  = i_q_data.ch;
                idle_pcls = i_q_data.cls;
            end
            default: begin
                idle_has = 1'b1;
                idle_res = ael_pkg::mk_status(ael_pkg::ST_UNKNOWN_CHAR);
            end
        endcase
    end

    // Scanner: next state and up to two results per character
    always_comb begin
        n_mode     = r_mode;
        n_count    = r_count;
        n_text     = r_text;
        n_pend_ch  = r_pend_ch;
        n_pend_cls = r_pend_cls;
        res_a      = idle_res;
        res_b      = idle_res;
        res_n      = 2'd0;
        word_res   = ael_pkg::mk_word((r_mode == ael_pkg::MODE_IDENT) ?
                                      ael_pkg::TT_IDENT : ael_pkg::TT_NUMBER,
                                      r_count, r_text);
        word_cont  = (i_q_data.cls == ael_pkg::CC_DIGIT) ||
                     (r_mode == ael_pkg::MODE_IDENT && i_q_data.cls == ael_pkg::CC_LETTER);
        op_checked = (r_pend_cls == ael_pkg::CC_OPEN) ||
                     (r_pend_cls == ael_pkg::CC_OP_CHECKED);

        unique case (r_mode)
            ael_pkg::MODE_NUMBER, ael_pkg::MODE_IDENT: begin
                if (word_cont) begin
                    if (r_count >= ael_pkg::MAX_LEN_COUNT) begin
                        res_a      = ael_pkg::mk_status(ael_pkg::ST_TOO_LONG);
                        res_n      = 2'd1;
                        n_mode     = ael_pkg::MODE_IDLE;
                        n_count    = '0;
                        n_pend_ch  = '0;
                        n_pend_cls = ael_pkg::CC_SPACE;
                    end else begin
                        n_text[ael_pkg::CHAR_W*r_count[ael_pkg::IDX_W-1:0] +:
                               ael_pkg::CHAR_W] = i_q_data.ch;
                        n_count = r_count + 1'b1;
                    end
                end else if (i_q_data.cls == ael_pkg::CC_SPACE) begin
                    res_a      = word_res;
                    res_n      = 2'd1;
                    n_mode     = ael_pkg::MODE_IDLE;
                    n_count    = '0;
                    n_pend_ch  = '0;
                    n_pend_cls = ael_pkg::CC_SPACE;
                end else if (i_q_data.cls == ael_pkg::CC_END ||
                             i_q_data.cls == ael_pkg::CC_OPEN ||
                             i_q_data.cls == ael_pkg::CC_CLOSE ||
                             i_q_data.cls == ael_pkg::CC_SEMI ||
                             i_q_data.cls == ael_pkg::CC_OP_CHECKED ||
                             i_q_data.cls == ael_pkg::CC_OP_STAR) begin
                    // word ends, then the character starts over as in idle
                    res_a      = word_res;
                    res_b      = idle_res;
                    res_n      = idle_has ? 2'd2 : 2'd1;
                    n_mode     = idle_mode;
                    n_count    = idle_count;
                    n_text     = idle_text;
                    n_pend_ch  = idle_pch;
                    n_pend_cls = idle_pcls;
                end else begin
                    // bad suffix: word dropped
                    res_a      = ael_pkg::mk_status(ael_pkg::ST_BAD_SUFFIX);
                    res_n      = 2'd1;
                    n_mode     = ael_pkg::MODE_IDLE;
                    n_count    = '0;
                    n_pend_ch  = '0;
                    n_pend_cls = ael_pkg::CC_SPACE;
                end
            end
            ael_pkg::MODE_OPER: begin
                if (i_q_data.cls == ael_pkg::CC_SPACE) begin
                    res_a      = ael_pkg::mk_oper(r_pend_ch, r_pend_cls);
                    res_n      = 2'd1;
                    n_mode     = ael_pkg::MODE_IDLE;
                    n_count    = '0;
                    n_pend_ch  = '0;
                    n_pend_cls = ael_pkg::CC_SPACE;
                end else if (op_checked &&
                             !(i_q_data.cls == ael_pkg::CC_LETTER ||
                               i_q_data.cls == ael_pkg::CC_DIGIT ||
                               i_q_data.cls == ael_pkg::CC_OPEN)) begin
                    // empty parentheses or doubled operator: held operator dropped
                    res_a      = ael_pkg::mk_status(
                                     (r_pend_cls == ael_pkg::CC_OPEN &&
                                      i_q_data.cls == ael_pkg::CC_CLOSE) ?
                                     ael_pkg::ST_EMPTY_PAREN : ael_pkg::ST_DOUBLED_OP);
                    res_n      = 2'd1;
                    n_mode     = ael_pkg::MODE_IDLE;
                    n_count    = '0;
                    n_pend_ch  = '0;
                    n_pend_cls = ael_pkg::CC_SPACE;
                end else begin
                    res_a      = ael_pkg::mk_oper(r_pend_ch, r_pend_cls);
                    res_b      = idle_res;
                    res_n      = idle_has ? 2'd2 : 2'd1;
                    n_mode     = idle_mode;
                    n_count    = idle_count;
                    n_text     = idle_text;
                    n_pend_ch  = idle_pch;
                    n_pend_cls = idle_pcls;
                end
            end
            default: begin
                res_a      = idle_res;
                res_n      = idle_has ? 2'd1 : 2'd0;
                n_mode     = idle_mode;
                n_count    = idle_count;
                n_text     = idle_text;
                n_pend_ch  = idle_pch;
                n_pend_cls = idle_pcls;
            end
        endcase

        // mark the last result of the character
        res_a.last = (res_n != 2'd2);
        res_b.last = 1'b1;
    end

    // Output stage: the held second result goes before any new character
    always_comb begin
        n_out          = r_out;
        n_out_valid    = r_out_valid;
        n_second       = r_second;
        n_second_valid = r_second_valid;
        if (out_free) begin
            if (r_second_valid) begin
                n_out          = r_second;
                n_out_valid    = 1'b1;
                n_second_valid = 1'b0;
            end else if (o_pop && res_n != 2'd0) begin
                n_out          = res_a;
                n_out_valid    = 1'b1;
                n_second       = res_b;
                n_second_valid = (res_n == 2'd2);
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= ael_pkg::MODE_IDLE;
            r_count        <= '0;
            r_pend_ch      <= '0;
            r_pend_cls     <= ael_pkg::CC_SPACE;
            r_out_valid    <= 1'b0;
            r_second_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode     <= n_mode;
                r_count    <= n_count;
                r_pend_ch  <= n_pend_ch;
                r_pend_cls <= n_pend_cls;
            end
            r_out_valid    <= n_out_valid;
            r_second_valid <= n_second_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_text <= n_text;
        end
        r_out    <= n_out;
        r_second <= n_second;
    end

    `AEL_ASSERT_SAME(a_second_behind_out, i_clk, i_rst_n, r_second_valid, r_out_valid)
    `AEL_ASSERT_SAME(a_no_pop_with_second, i_clk, i_rst_n, o_pop, !r_second_valid)
    `AEL_ASSERT_SAME(a_idle_no_word, i_clk, i_rst_n, r_mode == ael_pkg::MODE_IDLE, r_count == '0)
    `AEL_ASSERT_SAME(a_len_bound, i_clk, i_rst_n, 1'b1, r_count <= ael_pkg::MAX_LEN_COUNT)

endmodule

@@ rtl/arithmetic_expression_lexer.sv @@
// Streaming arithmetic expression lexer, one character per input beat, with
// tokens and end-of-expression status as output beats. A four-entry queue sits
// between the classifier and the scanner. The block takes one character per
// cycle while its queue has a free slot; a character that closes a word or held
// operator and also yields a result of its own ('#', an unknown character) gives
// two output beats, and the second waits in a holding slot behind the output
// register while the scanner takes no new character. An accepted input beat
// passes through the queue and then the output register on its way out.
// After '#' or any error status the scanner is idle and a new expression may
// follow at once.
`timescale 1ns / 1ps

module arithmetic_expression_lexer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ael_pkg::CHAR_W-1:0]    i_in_char,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic [1:0]                    o_token_type,
    output logic [ael_pkg::LEN_W-1:0]     o_token_length,
    output logic [ael_pkg::TEXT_W-1:0]    o_token_text,
    output logic [ael_pkg::STATUS_W-1:0]  o_status_code,
    output logic                          o_last_of_run
);

    logic             queue_full;
    logic             push;
    ael_pkg::t_entry  push_entry;
    logic             pop;
    logic             q_valid;
    ael_pkg::t_entry  q_data;
    ael_pkg::t_result result;

    ael_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_char    (i_in_char),
        .o_in_stall   (o_in_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    ael_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    ael_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    // Unpack the output beat onto its ports
    assign o_result_kind  = result.kind;
    assign o_token_type   = result.ttype;
    assign o_token_length = result.len;
    assign o_token_text   = result.text;
    assign o_status_code  = result.status;
    assign o_last_of_run  = result.last;

endmodule
